@@ sv/tdts_pkg.sv @@
// Shared types and constants for the tick-driven task table scheduler.
// Depends on nothing; every other file of the block imports it.
package tdts_pkg;

    localparam int SLOTS_DEF     = 8;
    localparam int ID_BITS       = 8;
    localparam int MS_PER_SECOND = 1000;

    // Command codes on the input beat
    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_ADD         = 3'd1,
        CMD_ADD_ONCE    = 3'd2,
        CMD_KILL        = 3'd3,
        CMD_RUN_STEP    = 3'd4,
        CMD_KILL_CUR    = 3'd5,
        CMD_REPLACE_CUR = 3'd6,
        CMD_FINISH      = 3'd7
    } t_cmd;

    // Slot status codes
    localparam logic [2:0] ST_READY        = 3'd0;
    localparam logic [2:0] ST_BLOCKED      = 3'd1;
    localparam logic [2:0] ST_TIMING       = 3'd2;
    localparam logic [2:0] ST_TIMING_READY = 3'd3;
    localparam logic [2:0] ST_TIMING_ONCE  = 3'd4;
    localparam logic [2:0] ST_RUN_ONCE     = 3'd5;
    localparam logic [2:0] ST_KILLED       = 3'd6;

    // Reply codes
    localparam logic [1:0] RPL_OK        = 2'd0;
    localparam logic [1:0] RPL_FULL      = 2'd1;
    localparam logic [1:0] RPL_NOT_FOUND = 2'd2;

    typedef struct packed {
        t_cmd        command;
        logic [7:0]  task_id;
        logic [2:0]  task_status;
        logic [15:0] reload_value;
        logic [15:0] start_count;
    } t_item;

    typedef struct packed {
        logic [1:0]  reply_code;
        logic        dispatched;
        logic [7:0]  run_task_id;
        logic        pass_done;
        logic [9:0]  ms_count;
        logic [31:0] seconds;
    } t_result;

    // Datapath operations issued by the controller, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_TICK,
        OP_SCAN_START,
        OP_SCAN_NEXT,
        OP_WRITE_IDX,
        OP_REPLY_FULL,
        OP_REPLY_NF,
        OP_KILL_IDX,
        OP_CLOCK,
        OP_TIMER,
        OP_ADVANCE,
        OP_DISPATCH,
        OP_SETTLE_ADV,
        OP_COMPACT_START,
        OP_COMPACT_MOVE,
        OP_COMPACT_END,
        OP_KILL_CUR,
        OP_REPLACE_CUR,
        OP_CLEAR_CALL,
        OP_OUT
    } t_op;

    // Datapath status seen by the controller
    typedef struct packed {
        t_cmd cmd;
        logic idx_task_zero;
        logic idx_task_match;
        logic idx_last;
        logic next_task_zero;
        logic cur_task_zero;
        logic cur_last;
        logic cur_zero;
        logic cur_runnable;
        logic cur_removable;
        logic in_call;
        logic pend_zero;
        logic out_free;
    } t_dp_status;

endpackage

@@ sv/tick_driven_task_table_scheduler.sv @@
// Top level of the tick-driven task table scheduler.
// Depends on tdts_pkg, tdts_ctrl and tdts_dp.
//
// Usage:
//   Input channel i_valid/o_ready carries one command beat (t_item): tick, add,
//   add_once, kill, run_step, kill_current, replace_current or finish.
//   Output channel o_valid/i_ready returns exactly one t_result beat per
//   command, in order: reply code, dispatch flag and id, pass_done and the
//   ms/seconds clock after the command.
//   Per command: tick, kill_current, replace_current and an ignored run_step or
//   finish go straight to the result. add/add_once/kill scan the table slot by
//   slot (add_once may scan the table twice). run_step does the timer sweep at
//   slot 0, then empty skips and compaction that together cover at most the
//   table; finish may compact the table. The single slot index walks the table
//   one entry per cycle. o_ready rises in the same cycle as o_valid, so the next
//   command can be accepted at once.
//   One command is handled at a time; o_ready is high only when idle.
//   A finished beat sits in the output register; the next command can be
//   accepted while it waits, and that command's result holds until the
//   receiver takes the earlier beat.
//   Reset (i_rst_n low, synchronous) empties every slot and clears the pass
//   position, pending ticks, clock and call flag; no clearing pass is needed.
module tick_driven_task_table_scheduler #(
    parameter int SLOTS = tdts_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tdts_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output tdts_pkg::t_result o_result
);
    import tdts_pkg::*;

    t_op        w_op;
    t_dp_status w_status;

    tdts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_ready  (o_ready),
        .o_op     (w_op)
    );

    tdts_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (w_op),
        .i_item   (i_item),
        .i_ready  (i_ready),
        .o_status (w_status),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // A step never dispatches and ends a pass in the same beat
    a_disp_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.dispatched && o_result.pass_done))
        else $error("dispatch and pass_done in one beat");

    // The ms field stays within a second
    a_ms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.ms_count < 10'(MS_PER_SECOND)))
        else $error("ms_count out of range");

    // The reply code uses only defined values
    a_reply_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.reply_code != 2'd3))
        else $error("undefined reply code");

    // After an accepted beat the block is busy in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("accepted a second beat back to back");

endmodule

@@ sv/tdts_dp.sv @@
// Datapath of the scheduler: slot table, pass/clock state and result register.
// Depends on tdts_pkg; driven one operation per cycle by tdts_ctrl.
module tdts_dp #(
    parameter int SLOTS = tdts_pkg::SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tdts_pkg::t_op        i_op,
    input  tdts_pkg::t_item      i_item,
    input  logic                 i_ready,
    output tdts_pkg::t_dp_status o_status,
    output logic                 o_valid,
    output tdts_pkg::t_result    o_result
);
    import tdts_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

    logic [ID_BITS-1:0] r_task [SLOTS];
    logic [2:0]         r_stat [SLOTS];
    logic [15:0]        r_rel  [SLOTS];
    logic [15:0]        r_cd   [SLOTS];

    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_cur;
    logic [31:0]   r_pend;
    logic [9:0]    r_ms;
    logic [31:0]   r_sec;
    logic          r_call;
    logic          r_ovalid;
    t_item         r_item;
    t_result       r_out;
    logic [1:0]    r_reply;
    logic          r_disp;
    logic [7:0]    r_run_id;
    logic          r_done;

    logic [SW-1:0]      idx_nxt;
    logic [ID_BITS-1:0] nxt_task;
    logic [ID_BITS-1:0] item_id;
    logic [2:0]         cur_st;
    logic [2:0]         idx_st;
    logic [15:0]        cd_dec;
    logic               idx_timing;
    logic [9:0]         ms_inc;

    // Look at the slot after the index and at the current slot
    assign idx_nxt  = r_idx + 1'b1;
    assign nxt_task = (r_idx == LAST) ? '0 : r_task[idx_nxt];
    assign item_id  = r_item.task_id[ID_BITS-1:0];
    assign cur_st   = r_stat[r_cur];
    assign idx_st   = r_stat[r_idx];
    assign cd_dec   = (r_cd[r_idx] != 16'd0) ? r_cd[r_idx] - 16'd1 : r_cd[r_idx];
    assign idx_timing = (r_task[r_idx] != '0) &&
                        (idx_st == ST_TIMING || idx_st == ST_TIMING_ONCE);
    assign ms_inc   = r_ms + 10'd1;

    always_comb begin
        o_status.cmd            = r_item.command;
        o_status.idx_task_zero  = (r_task[r_idx] == '0);
        o_status.idx_task_match = (r_task[r_idx] == item_id);
        o_status.idx_last       = (r_idx == LAST);
        o_status.next_task_zero = (nxt_task == '0);
        o_status.cur_task_zero  = (r_task[r_cur] == '0);
        o_status.cur_last       = (r_cur == LAST);
        o_status.cur_zero       = (r_cur == '0);
        o_status.cur_runnable   = (cur_st == ST_READY) || (cur_st == ST_RUN_ONCE) ||
                                  (cur_st == ST_TIMING_READY);
        o_status.cur_removable  = (cur_st == ST_RUN_ONCE) || (cur_st == ST_KILLED);
        o_status.in_call        = r_call;
        o_status.pend_zero      = (r_pend == 32'd0);
        o_status.out_free       = !r_ovalid || i_ready;
    end

    // Control state: task ids, pass position, pending ticks, clock, call flag, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_task[s] <= '0;
            end
            r_cur    <= '0;
            r_pend   <= '0;
            r_ms     <= '0;
            r_sec    <= '0;
            r_call   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // Raise valid on a new result, drop it once the beat is taken
            if (i_op == OP_OUT) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (i_op)
                OP_TICK: begin
                    if (r_pend != 32'hFFFF_FFFF) begin
                        r_pend <= r_pend + 32'd1;
                    end
                end
                OP_WRITE_IDX:    r_task[r_idx] <= item_id;
                OP_CLOCK: begin
                    if (ms_inc >= 10'(MS_PER_SECOND)) begin
                        r_ms  <= '0;
                        r_sec <= r_sec + 32'd1;
                    end else begin
                        r_ms <= ms_inc;
                    end
                end
                OP_ADVANCE, OP_SETTLE_ADV: begin
                    if (r_cur == LAST) begin
                        r_cur <= '0;
                        if (r_pend != 32'd0) begin
                            r_pend <= r_pend - 32'd1;
                        end
                    end else begin
                        r_cur <= r_cur + 1'b1;
                    end
                end
                OP_DISPATCH:     r_call <= 1'b1;
                OP_CLEAR_CALL:   r_call <= 1'b0;
                OP_COMPACT_MOVE: r_task[r_idx] <= nxt_task;
                OP_COMPACT_END:  r_task[r_idx] <= '0;
                OP_REPLACE_CUR:  r_task[r_cur] <= item_id;
                default: ;
            endcase
        end
    end

    // Payload: slot fields, scan index, latched beat and results
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LATCH: begin
                r_item   <= i_item;
                r_reply  <= RPL_OK;
                r_disp   <= 1'b0;
                r_run_id <= '0;
                r_done   <= 1'b0;
            end
            OP_SCAN_START, OP_CLOCK: r_idx <= '0;
            OP_SCAN_NEXT:  r_idx <= idx_nxt;
            OP_WRITE_IDX: begin
                r_stat[r_idx] <= r_item.task_status;
                r_rel[r_idx]  <= r_item.reload_value;
                r_cd[r_idx]   <= r_item.start_count;
            end
            OP_REPLY_FULL: r_reply <= RPL_FULL;
            OP_REPLY_NF:   r_reply <= RPL_NOT_FOUND;
            OP_KILL_IDX:   r_stat[r_idx] <= ST_KILLED;
            OP_TIMER: begin
                // Count down one timing slot and step to the next
                if (idx_timing) begin
                    r_cd[r_idx] <= cd_dec;
                    if (cd_dec == 16'd0) begin
                        r_stat[r_idx] <= (idx_st == ST_TIMING) ? ST_TIMING_READY
                                                               : ST_RUN_ONCE;
                    end
                end
                r_idx <= idx_nxt;
            end
            OP_ADVANCE: begin
                if (r_cur == LAST) begin
                    r_done <= 1'b1;
                end
            end
            OP_DISPATCH: begin
                r_disp   <= 1'b1;
                r_run_id <= 8'(r_task[r_cur]);
            end
            OP_SETTLE_ADV: begin
                if (cur_st == ST_TIMING_READY) begin
                    r_stat[r_cur] <= ST_TIMING;
                    r_cd[r_cur]   <= r_rel[r_cur];
                end
                if (r_cur == LAST) begin
                    r_done <= 1'b1;
                end
            end
            OP_COMPACT_START: r_idx <= r_cur;
            OP_COMPACT_MOVE: begin
                r_stat[r_idx] <= r_stat[idx_nxt];
                r_rel[r_idx]  <= r_rel[idx_nxt];
                r_cd[r_idx]   <= r_cd[idx_nxt];
                r_idx         <= idx_nxt;
            end
            OP_KILL_CUR: r_stat[r_cur] <= ST_KILLED;
            OP_REPLACE_CUR: begin
                r_stat[r_cur] <= r_item.task_status;
                r_rel[r_cur]  <= r_item.reload_value;
                r_cd[r_cur]   <= r_item.start_count;
            end
            OP_OUT: begin
                r_out.reply_code  <= r_reply;
                r_out.dispatched  <= r_disp;
                r_out.run_task_id <= r_run_id;
                r_out.pass_done   <= r_done;
                r_out.ms_count    <= r_ms;
                r_out.seconds     <= r_sec;
            end
            default: ;
        endcase
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_out;

endmodule

@@ sv/tdts_ctrl.sv @@
// Controller of the scheduler: sequences datapath operations for each command.
// Depends on tdts_pkg; talks to tdts_dp through t_op and t_dp_status only.
module tdts_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  tdts_pkg::t_dp_status i_status,
    output logic                 o_ready,
    output tdts_pkg::t_op        o_op
);
    import tdts_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE       = 11'b00000000001,
        S_DECODE     = 11'b00000000010,
        S_SCAN_FREE  = 11'b00000000100,
        S_SCAN_MATCH = 11'b00000001000,
        S_SCAN_KILL  = 11'b00000010000,
        S_TIMERS     = 11'b00000100000,
        S_SKIP       = 11'b00001000000,
        S_CHECK      = 11'b00010000000,
        S_SETTLE     = 11'b00100000000,
        S_COMPACT    = 11'b01000000000,
        S_DONE       = 11'b10000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    // Pick the operation and next state
    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_op    = OP_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.cmd)
                    CMD_TICK: begin
                        o_op    = OP_TICK;
                        n_state = S_DONE;
                    end
                    CMD_ADD: begin
                        o_op    = OP_SCAN_START;
                        n_state = S_SCAN_FREE;
                    end
                    CMD_ADD_ONCE: begin
                        o_op    = OP_SCAN_START;
                        n_state = S_SCAN_MATCH;
                    end
                    CMD_KILL: begin
                        o_op    = OP_SCAN_START;
                        n_state = S_SCAN_KILL;
                    end
                    CMD_RUN_STEP: begin
                        if (i_status.in_call || i_status.pend_zero) begin
                            n_state = S_DONE;
                        end else if (i_status.cur_zero) begin
                            o_op    = OP_CLOCK;
                            n_state = S_TIMERS;
                        end else begin
                            n_state = S_SKIP;
                        end
                    end
                    CMD_KILL_CUR: begin
                        o_op    = OP_KILL_CUR;
                        n_state = S_DONE;
                    end
                    CMD_REPLACE_CUR: begin
                        o_op    = OP_REPLACE_CUR;
                        n_state = S_DONE;
                    end
                    CMD_FINISH: begin
                        if (i_status.in_call) begin
                            o_op    = OP_CLEAR_CALL;
                            n_state = S_SETTLE;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN_FREE: begin
                priority if (i_status.idx_task_zero) begin
                    o_op    = OP_WRITE_IDX;
                    n_state = S_DONE;
                end else if (i_status.idx_last) begin
                    o_op    = OP_REPLY_FULL;
                    n_state = S_DONE;
                end else begin
                    o_op = OP_SCAN_NEXT;
                end
            end
            S_SCAN_MATCH: begin
                priority if (i_status.idx_task_match) begin
                    o_op    = OP_WRITE_IDX;
                    n_state = S_DONE;
                end else if (i_status.idx_last) begin
                    o_op    = OP_SCAN_START;
                    n_state = S_SCAN_FREE;
                end else begin
                    o_op = OP_SCAN_NEXT;
                end
            end
            S_SCAN_KILL: begin
                priority if (i_status.idx_task_match) begin
                    o_op    = OP_KILL_IDX;
                    n_state = S_DONE;
                end else if (i_status.idx_last) begin
                    o_op    = OP_REPLY_NF;
                    n_state = S_DONE;
                end else begin
                    o_op = OP_SCAN_NEXT;
                end
            end
            S_TIMERS: begin
                o_op = OP_TIMER;
                if (i_status.idx_last) begin
                    n_state = S_SKIP;
                end
            end
            // Skip empty slots; wrapping past the last one ends the pass
            S_SKIP: begin
                if (!i_status.cur_task_zero) begin
                    n_state = S_CHECK;
                end else begin
                    o_op = OP_ADVANCE;
                    if (i_status.cur_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CHECK: begin
                if (i_status.cur_runnable) begin
                    o_op    = OP_DISPATCH;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SETTLE;
                end
            end
            S_SETTLE: begin
                if (i_status.cur_removable) begin
                    o_op    = OP_COMPACT_START;
                    n_state = S_COMPACT;
                end else begin
                    o_op    = OP_SETTLE_ADV;
                    n_state = S_DONE;
                end
            end
            // Shift later slots up until the last or first empty slot
            S_COMPACT: begin
                if (i_status.idx_last || i_status.next_task_zero) begin
                    o_op    = OP_COMPACT_END;
                    n_state = S_DONE;
                end else begin
                    o_op = OP_COMPACT_MOVE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
